@@ sv/nnga_pkg.sv @@
package nnga_pkg;

   // grid geometry
   localparam int GRID_X     = 16;
   localparam int GRID_Y     = 16;
   localparam int GRID_Z     = 16;
   localparam int MAX_ECHOES = 4;
   localparam int CHANNELS   = 2;

   localparam int CELL_COUNT = CHANNELS * MAX_ECHOES * GRID_Z * GRID_Y * GRID_X;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int KIND_W     = 2;
   localparam int CHANNEL_W  = 1;
   localparam int ECHO_W     = 7;
   localparam int COORD_W    = 4;
   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 16;
   localparam int CELL_W     = 24;
   localparam int ECOUNT_W   = 3;
   localparam int ENTRY_W    = 2 * CELL_W;

   // weighted product, rounded contribution and unsaturated sum
   localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;
   localparam int FRAC_SHIFT = 14;
   localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
   localparam int CONTRIB_W  = PROD_W - FRAC_SHIFT;
   localparam int SUM_W      = CELL_W + 1;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

   // cell coordinates of one item, before clamping
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [ECHO_W-1:0]    echo_index;
      logic [COORD_W-1:0]   cell_x;
      logic [COORD_W-1:0]   cell_y;
      logic [COORD_W-1:0]   cell_z;
   } coord_type;

endpackage

@@ sv/nearest_neighbour_grid_accumulate.sv @@
// channel  direction  beat contents
// req_     in         tuser: kind; tdata: channel, echo_index, cell_x/y/z, sample_re/im,
//                     dc_weight, load_re/im
// rsp_     out        tdata: value_re, value_im (read items only)
// csr_     in         echo_count write, no read-back
//
// each item passes through accept, grid memory read, and update or reply; an unused
// kind is only accepted. the registered read of the grid memory sets these steps, and
// the next item is not taken until the write back is done.
// after reset a clearing pass writes zero to all 32768 cells, one per cycle, while
// req_tready stays low; csr writes are taken throughout.
// a read item waits in its last cycle while the previous reply beat is still pending.
module nearest_neighbour_grid_accumulate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata from bit 0: channel, echo_index, cell_x, cell_y, cell_z, sample_re,
   // sample_im, dc_weight, load_re, load_im, zero pad
   input  logic [119:0]                     req_tdata,
   // tuser: kind
   input  logic [nnga_pkg::KIND_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata from bit 0: value_re, value_im
   output logic [47:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [nnga_pkg::ECOUNT_W-1:0]    csr_wdata
);
   import nnga_pkg::*;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [ADDR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [ECOUNT_W-1:0]        echo_count_ff, echo_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]         rsp_data_ff, rsp_data_in;

   logic [KIND_W-1:0]          kind_ff, kind_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic signed [SAMPLE_W-1:0] sre_ff, sre_in;
   logic signed [SAMPLE_W-1:0] sim_ff, sim_in;
   logic [WEIGHT_W-1:0]        weight_ff, weight_in;
   logic [CELL_W-1:0]          lre_ff, lre_in;
   logic [CELL_W-1:0]          lim_ff, lim_in;

   coord_type                  coord;
   logic                       accept;
   logic                       out_free;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [ENTRY_W-1:0]         ram_wdata;
   logic [ENTRY_W-1:0]         ram_rdata;
   logic signed [CELL_W-1:0]   sum_re;
   logic signed [CELL_W-1:0]   sum_im;

   // unpack the request beat
   always_comb begin
      coord.channel    = req_tdata[0];
      coord.echo_index = req_tdata[7:1];
      coord.cell_x     = req_tdata[11:8];
      coord.cell_y     = req_tdata[15:12];
      coord.cell_z     = req_tdata[19:16];
      sre_in           = req_tdata[35:20];
      sim_in           = req_tdata[51:36];
      weight_in        = req_tdata[67:52];
      lre_in           = req_tdata[91:68];
      lim_in           = req_tdata[115:92];
      kind_in          = req_tuser;
   end

   nnga_index u_index (
      .coord      (coord),
      .echo_count (echo_count_ff),
      .addr       (addr_in)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (int'(clr_cnt_ff) == CELL_COUNT - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_tuser != KIND_NONE) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (kind_ff != KIND_READ || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration register
   assign echo_count_in = csr_we ? csr_wdata : echo_count_ff;

   // weighted sum for each part
   nnga_mac u_mac_re (
      .clock  (clock),
      .sample (sre_ff),
      .weight (weight_ff),
      .base   (ram_rdata[CELL_W-1:0]),
      .sum    (sum_re)
   );

   nnga_mac u_mac_im (
      .clock  (clock),
      .sample (sim_ff),
      .weight (weight_ff),
      .base   (ram_rdata[ENTRY_W-1:CELL_W]),
      .sum    (sum_im)
   );

   // memory write: clearing pass, or write back of accumulate and load
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = {lim_ff, lre_ff};
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (state_ff == S_UPDATE) begin
         if (kind_ff == KIND_ACC) begin
            ram_we    = 1'b1;
            ram_wdata = {sum_im, sum_re};
         end else if (kind_ff == KIND_WRITE) begin
            ram_we    = 1'b1;
         end
      end
   end

   nnga_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELL_COUNT)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // reply register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_UPDATE && kind_ff == KIND_READ && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         echo_count_ff <= ECOUNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         echo_count_ff <= echo_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item and reply payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff   <= kind_in;
         addr_ff   <= addr_in;
         sre_ff    <= sre_in;
         sim_ff    <= sim_in;
         weight_ff <= weight_in;
         lre_ff    <= lre_in;
         lim_ff    <= lim_in;
      end
   end

endmodule

@@ sv/nnga_ram.sv @@
module nnga_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/nnga_index.sv @@
module nnga_index (
   input  nnga_pkg::coord_type             coord,
   input  logic [nnga_pkg::ECOUNT_W-1:0]   echo_count,
   output logic [nnga_pkg::ADDR_W-1:0]     addr
);
   import nnga_pkg::*;

   logic [ECOUNT_W-1:0]  ec_eff;
   logic [ECOUNT_W-1:0]  ec_last;
   logic [CHANNEL_W-1:0] ch_c;
   logic [ECHO_W-1:0]    e_c;
   logic [COORD_W-1:0]   x_c;
   logic [COORD_W-1:0]   y_c;
   logic [COORD_W-1:0]   z_c;

   // effective echo count: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (echo_count == '0) begin
         ec_eff = ECOUNT_W'(1);
      end else if (int'(echo_count) > MAX_ECHOES) begin
         ec_eff = ECOUNT_W'(MAX_ECHOES);
      end else begin
         ec_eff = echo_count;
      end
      ec_last = ec_eff - ECOUNT_W'(1);
   end

   // clamp each coordinate to the last plane or cell
   always_comb begin
      ch_c = (int'(coord.channel) > CHANNELS - 1) ? CHANNEL_W'(CHANNELS - 1) : coord.channel;
      e_c  = (coord.echo_index > ECHO_W'(ec_last)) ? ECHO_W'(ec_last) : coord.echo_index;
      x_c  = (int'(coord.cell_x) > GRID_X - 1) ? COORD_W'(GRID_X - 1) : coord.cell_x;
      y_c  = (int'(coord.cell_y) > GRID_Y - 1) ? COORD_W'(GRID_Y - 1) : coord.cell_y;
      z_c  = (int'(coord.cell_z) > GRID_Z - 1) ? COORD_W'(GRID_Z - 1) : coord.cell_z;
   end

   // linear cell address: channel, echo, z, y, x from the top down
   assign addr = ADDR_W'(((((int'(ch_c) * MAX_ECHOES + int'(e_c)) * GRID_Z + int'(z_c))
                          * GRID_Y + int'(y_c)) * GRID_X + int'(x_c)));

endmodule

@@ sv/nnga_mac.sv @@
module nnga_mac (
   input  logic                                clock,
   input  logic signed [nnga_pkg::SAMPLE_W-1:0] sample,
   input  logic        [nnga_pkg::WEIGHT_W-1:0] weight,
   input  logic signed [nnga_pkg::CELL_W-1:0]   base,
   output logic signed [nnga_pkg::CELL_W-1:0]   sum
);
   import nnga_pkg::*;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    biased;
   logic signed [CONTRIB_W-1:0] contrib;
   logic signed [SUM_W-1:0]     total;

   // exact product of signed sample and unsigned weight
   assign prod_in = PROD_W'(sample * $signed({1'b0, weight}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up to the cell format, then add into the cell
   always_comb begin
      biased  = prod_ff + PROD_W'(ROUND_BIAS);
      contrib = CONTRIB_W'(biased >>> FRAC_SHIFT);
      total   = SUM_W'(base) + SUM_W'(contrib);
   end

   // saturate to the cell range
   always_comb begin
      if (total[SUM_W-1] != total[SUM_W-2]) begin
         sum = total[SUM_W-1] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
      end else begin
         sum = total[CELL_W-1:0];
      end
   end

endmodule
